>>> src/brcs_pkg.sv
// ----------------------------------------------------------------------------
// Bezier curve record setup: shared package
// Field types of the input and result channels, the job record that passes
// from the front end to the coefficient back end, and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package brcs_pkg;

  // Fixed-point format of the coordinates.
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COEFF_W   = COORD_W + 4;
  localparam int unsigned SAMPLE_W  = 31;
  localparam int unsigned COLOUR_W  = 32;

  localparam int unsigned NUM_POINTS = 4;
  localparam int unsigned NUM_AXES   = 3;

  // Degree codes carried by a finish item; anything else is treated as cubic.
  localparam logic [1:0] DEG_LINEAR = 2'd1;
  localparam logic [1:0] DEG_QUAD   = 2'd2;

  // Coefficient slot that closes a record.
  localparam logic [1:0] SLOT_K3 = 2'd3;

  typedef enum logic [1:0] {
    KIND_POINT        = 2'd0,
    KIND_START_COLOUR = 2'd1,
    KIND_END_COLOUR   = 2'd2,
    KIND_FINISH       = 2'd3
  } kind_e;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [COEFF_W-1:0]  coeff_t;
  typedef logic        [SAMPLE_W-1:0] sample_t;
  typedef logic        [COLOUR_W-1:0] colour_t;

  localparam sample_t SAMPLE_MAX = '1;

  typedef struct packed {
    kind_e                     kind;
    logic signed [VALUE_W-1:0] value_x;
    logic signed [VALUE_W-1:0] value_y;
    logic signed [VALUE_W-1:0] value_z;
    logic [1:0]                point_slot;
    logic [1:0]                degree;
    logic [15:0]               sample_count;
    logic                      joins_previous;
  } in_item_t;

  typedef struct packed {
    coeff_t     coeff_x;
    coeff_t     coeff_y;
    coeff_t     coeff_z;
    logic [1:0] coeff_slot;
    sample_t    first_sample;
    sample_t    last_sample;
    sample_t    chain_first;
    colour_t    colour_start;
    colour_t    colour_end;
    logic       last_of_record;
  } out_item_t;

  // Per-record fields that ride along with the coefficients unchanged.
  typedef struct packed {
    sample_t first_sample;
    sample_t last_sample;
    sample_t chain_first;
    colour_t colour_start;
    colour_t colour_end;
  } rec_meta_t;

  // One finished curve as handed from the front end to the back end.
  typedef struct packed {
    coord_t [NUM_POINTS-1:0][NUM_AXES-1:0] pts;
    logic [1:0]                            degree;
    rec_meta_t                             meta;
  } job_t;

endpackage

`default_nettype wire

>>> src/brcs_front.sv
// ----------------------------------------------------------------------------
// Bezier curve record setup: front end
// Accepts input items, keeps the control points and packed colours, assigns
// the sample range of each finished curve and issues a job per finish item.
// ----------------------------------------------------------------------------
`default_nettype none

module brcs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  brcs_pkg::in_item_t in_item_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output brcs_pkg::job_t     job_o
);
  import brcs_pkg::*;

  localparam coord_t OneQ = coord_t'(1 << FRAC_BITS);

  // Clamp a channel to [0, 1.0] and scale it to a rounded byte.
  function automatic logic [7:0] pack_byte(input coord_t v);
    logic [FRAC_BITS:0]   clamped;
    logic [FRAC_BITS+8:0] scaled;
    if (v[COORD_W-1]) begin
      clamped = '0;
    end else if (v > OneQ) begin
      clamped = OneQ[FRAC_BITS:0];
    end else begin
      clamped = v[FRAC_BITS:0];
    end
    scaled = {clamped, 8'd0} - (FRAC_BITS+9)'(clamped)
             + (FRAC_BITS+9)'(1 << (FRAC_BITS-1));
    return scaled[FRAC_BITS +: 8];
  endfunction

  function automatic colour_t pack_colour(input in_item_t item);
    return {8'hFF, pack_byte(coord_t'(item.value_z)), pack_byte(coord_t'(item.value_y)),
            pack_byte(coord_t'(item.value_x))};
  endfunction

  coord_t  store_q [NUM_POINTS][NUM_AXES];
  colour_t start_q, end_q;
  sample_t next_q, chain_q;
  logic    seen_q;

  logic    in_transfer;
  logic    new_chain;
  sample_t first, last, next_d, chain_d;
  logic [15:0]       span;
  logic [SAMPLE_W:0] last_wide;

  // Items of every kind are held off while the queue is full.
  assign in_ready_o  = job_ready_i;
  assign in_transfer = in_valid_i && in_ready_o;
  assign job_valid_o = in_valid_i && (in_item_i.kind == KIND_FINISH);

  // Sample range of the curve carried by a finish item.
  always_comb begin
    new_chain = !seen_q || !in_item_i.joins_previous;
    if (new_chain) begin
      first = next_q;
    end else if (next_q != '0) begin
      first = next_q - 1'b1;
    end else begin
      first = '0;
    end
    span      = (in_item_i.sample_count == 16'd0) ? 16'd0 : in_item_i.sample_count - 16'd1;
    last_wide = {1'b0, first} + (SAMPLE_W+1)'(span);
    last      = last_wide[SAMPLE_W] ? SAMPLE_MAX : last_wide[SAMPLE_W-1:0];
    next_d    = (last == SAMPLE_MAX) ? SAMPLE_MAX : last + 1'b1;
    chain_d   = new_chain ? first : chain_q;
  end

  // Job record: a snapshot of the points and colours at the finish item.
  always_comb begin
    for (int s = 0; s < NUM_POINTS; s++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        job_o.pts[s][c] = store_q[s][c];
      end
    end
    job_o.degree            = in_item_i.degree;
    job_o.meta.first_sample = first;
    job_o.meta.last_sample  = last;
    job_o.meta.chain_first  = chain_d;
    job_o.meta.colour_start = start_q;
    job_o.meta.colour_end   = end_q;
  end

  // Control point store; entries are undefined until written.
  always_ff @(posedge clk_i) begin
    if (in_transfer && in_item_i.kind == KIND_POINT) begin
      store_q[in_item_i.point_slot][0] <= coord_t'(in_item_i.value_x);
      store_q[in_item_i.point_slot][1] <= coord_t'(in_item_i.value_y);
      store_q[in_item_i.point_slot][2] <= coord_t'(in_item_i.value_z);
    end
  end

  // Colours and sample bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
      next_q  <= '0;
      chain_q <= '0;
      seen_q  <= 1'b0;
    end else if (in_transfer) begin
      unique case (in_item_i.kind)
        KIND_START_COLOUR: start_q <= pack_colour(in_item_i);
        KIND_END_COLOUR:   end_q   <= pack_colour(in_item_i);
        KIND_FINISH: begin
          next_q  <= next_d;
          chain_q <= chain_d;
          seen_q  <= 1'b1;
        end
        KIND_POINT: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/brcs_queue.sv
// ----------------------------------------------------------------------------
// Bezier curve record setup: job queue
// A small first-in first-out queue that lets the front end and the back end
// stall independently of each other.
// ----------------------------------------------------------------------------
`default_nettype none

module brcs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Storage; entries carry no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/brcs_back.sv
// ----------------------------------------------------------------------------
// Bezier curve record setup: coefficient back end
// Degree elevation by rounded thirds, forward differences to monomial
// coefficients, and a sequencer that emits the four results of each record
// through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brcs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  brcs_pkg::job_t      job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output brcs_pkg::out_item_t out_item_o
);
  import brcs_pkg::*;

  // The rounded third floor((n+1)/3) is taken on n + 1 + 3*2^COORD_W, which is
  // positive, split into a high and a low part, each divided by a reciprocal.
  localparam int unsigned UW    = COORD_W + 3;
  localparam int unsigned LO_W  = (UW + 1) / 2;
  localparam int unsigned HI_W  = UW - LO_W;
  localparam int unsigned X_W   = LO_W + 2;
  localparam int unsigned DIV_S = X_W + 2 + (X_W % 2);
  localparam longint unsigned DIV_R = ((64'd1 << DIV_S) + 64'd2) / 64'd3;
  localparam logic [UW:0] OffsetU = (UW+1)'({2'b11, {COORD_W{1'b0}}});

  // Exact floor(x/3) for x below 2^X_W.
  function automatic logic [X_W-1:0] div3(input logic [X_W-1:0] x);
    logic [X_W+DIV_S-1:0] prod;
    prod = (X_W+DIV_S)'(x) * (X_W+DIV_S)'(DIV_R);
    return prod[DIV_S +: X_W];
  endfunction

  // Stage A: dividends.
  logic            va_q;
  logic [UW-1:0]   ua_q   [2][NUM_AXES];
  logic [UW-1:0]   ua_d   [2][NUM_AXES];
  coord_t          pa0_q  [NUM_AXES];
  coord_t          pa3_q  [NUM_AXES];
  coord_t          pa3_d  [NUM_AXES];
  rec_meta_t       meta_a_q;
  // Stage B: high quotient.
  logic            vb_q;
  logic [HI_W-1:0] hi_q   [2][NUM_AXES];
  logic [HI_W-1:0] qhi_q  [2][NUM_AXES];
  logic [HI_W-1:0] qhi_d  [2][NUM_AXES];
  logic [LO_W-1:0] lo_q   [2][NUM_AXES];
  coord_t          pb0_q  [NUM_AXES];
  coord_t          pb3_q  [NUM_AXES];
  rec_meta_t       meta_b_q;
  // Stage C: elevated control points.
  logic            vc_q;
  coord_t          pc_q   [NUM_POINTS][NUM_AXES];
  coord_t          pmid_d [2][NUM_AXES];
  rec_meta_t       meta_c_q;
  // Stage D: first differences.
  logic            vd_q;
  logic signed [COORD_W:0] dif_q [3][NUM_AXES];
  logic signed [COORD_W:0] dif_d [3][NUM_AXES];
  coord_t          pd0_q  [NUM_AXES];
  rec_meta_t       meta_d_q;
  // Emitter.
  logic            busy_q;
  logic [1:0]      beat_q;
  coeff_t          k_q    [NUM_POINTS][NUM_AXES];
  coeff_t          k_d    [NUM_POINTS][NUM_AXES];
  rec_meta_t       meta_e_q;
  // Output register.
  logic            out_valid_q;
  out_item_t       out_item_q;
  out_item_t       out_item_d;

  logic adv_a, adv_b, adv_c, adv_d, em_ready, em_load, out_load;

  // Flow control: a stage takes new data when empty or when it moves on.
  assign out_load    = busy_q && (!out_valid_q || out_ready_i);
  assign em_ready    = !busy_q || (out_load && beat_q == SLOT_K3);
  assign em_load     = vd_q && em_ready;
  assign adv_d       = !vd_q || em_ready;
  assign adv_c       = !vc_q || adv_d;
  assign adv_b       = !vb_q || adv_c;
  assign adv_a       = !va_q || adv_b;
  assign job_ready_o = adv_a;

  // Stage A: pick the operands of each rounded third from the degree. A cubic
  // curve takes 3*P1 and 3*P2, whose thirds give the points back unchanged.
  always_comb begin
    coord_t a, b, d, e, s1, t1, s2, t2;
    logic   rnd;
    for (int c = 0; c < NUM_AXES; c++) begin
      a = job_i.pts[0][c];
      b = job_i.pts[1][c];
      d = job_i.pts[2][c];
      e = job_i.pts[3][c];
      unique case (job_i.degree)
        DEG_LINEAR: begin
          s1 = b; t1 = a; s2 = a; t2 = b; rnd = 1'b1; pa3_d[c] = b;
        end
        DEG_QUAD: begin
          s1 = a; t1 = b; s2 = d; t2 = b; rnd = 1'b1; pa3_d[c] = d;
        end
        default: begin
          s1 = b; t1 = b; s2 = d; t2 = d; rnd = 1'b0; pa3_d[c] = e;
        end
      endcase
      ua_d[0][c] = UW'((UW+1)'(s1) + ((UW+1)'(t1) <<< 1) + (UW+1)'(rnd) + OffsetU);
      ua_d[1][c] = UW'((UW+1)'(s2) + ((UW+1)'(t2) <<< 1) + (UW+1)'(rnd) + OffsetU);
    end
  end

  // Stage B: quotient of the high part.
  always_comb begin
    logic [X_W-1:0] quo;
    for (int j = 0; j < 2; j++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        quo         = div3(X_W'(ua_q[j][c][UW-1:LO_W]));
        qhi_d[j][c] = quo[HI_W-1:0];
      end
    end
  end

  // Stage C: the high remainder joins the low part for the second division.
  always_comb begin
    logic [HI_W-1:0] rem;
    logic [X_W-1:0]  qlo;
    logic [UW-1:0]   quo;
    for (int j = 0; j < 2; j++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        rem          = hi_q[j][c] - (qhi_q[j][c] + (qhi_q[j][c] << 1));
        qlo          = div3({rem[1:0], lo_q[j][c]});
        quo          = {qhi_q[j][c], qlo[LO_W-1:0]};
        // The offset is a multiple of 2^COORD_W and drops out of the low bits.
        pmid_d[j][c] = coord_t'(quo[COORD_W-1:0]);
      end
    end
  end

  // Stage D: first differences of the elevated points.
  always_comb begin
    for (int c = 0; c < NUM_AXES; c++) begin
      for (int i = 0; i < 3; i++) begin
        dif_d[i][c] = (COORD_W+1)'(pc_q[i+1][c]) - (COORD_W+1)'(pc_q[i][c]);
      end
    end
  end

  // Emitter load: monomial coefficients. The field is wide enough that no
  // coefficient can overflow, so there is nothing to saturate.
  always_comb begin
    logic signed [COORD_W+1:0] dd0, dd1;
    for (int c = 0; c < NUM_AXES; c++) begin
      dd0       = (COORD_W+2)'(dif_q[1][c]) - (COORD_W+2)'(dif_q[0][c]);
      dd1       = (COORD_W+2)'(dif_q[2][c]) - (COORD_W+2)'(dif_q[1][c]);
      k_d[0][c] = COEFF_W'(pd0_q[c]);
      k_d[1][c] = (COEFF_W'(dif_q[0][c]) <<< 1) + COEFF_W'(dif_q[0][c]);
      k_d[2][c] = (COEFF_W'(dd0) <<< 1) + COEFF_W'(dd0);
      k_d[3][c] = COEFF_W'(dd1) - COEFF_W'(dd0);
    end
  end

  // Result for the current beat.
  always_comb begin
    out_item_d.coeff_x        = k_q[beat_q][0];
    out_item_d.coeff_y        = k_q[beat_q][1];
    out_item_d.coeff_z        = k_q[beat_q][2];
    out_item_d.coeff_slot     = beat_q;
    out_item_d.first_sample   = meta_e_q.first_sample;
    out_item_d.last_sample    = meta_e_q.last_sample;
    out_item_d.chain_first    = meta_e_q.chain_first;
    out_item_d.colour_start   = meta_e_q.colour_start;
    out_item_d.colour_end     = meta_e_q.colour_end;
    out_item_d.last_of_record = (beat_q == SLOT_K3);
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      ua_q     <= ua_d;
      pa3_q    <= pa3_d;
      meta_a_q <= job_i.meta;
      for (int c = 0; c < NUM_AXES; c++) begin
        pa0_q[c] <= job_i.pts[0][c];
      end
    end
    if (adv_b) begin
      qhi_q    <= qhi_d;
      pb0_q    <= pa0_q;
      pb3_q    <= pa3_q;
      meta_b_q <= meta_a_q;
      for (int j = 0; j < 2; j++) begin
        for (int c = 0; c < NUM_AXES; c++) begin
          hi_q[j][c] <= ua_q[j][c][UW-1:LO_W];
          lo_q[j][c] <= ua_q[j][c][LO_W-1:0];
        end
      end
    end
    if (adv_c) begin
      meta_c_q <= meta_b_q;
      for (int c = 0; c < NUM_AXES; c++) begin
        pc_q[0][c] <= pb0_q[c];
        pc_q[1][c] <= pmid_d[0][c];
        pc_q[2][c] <= pmid_d[1][c];
        pc_q[3][c] <= pb3_q[c];
      end
    end
    if (adv_d) begin
      dif_q    <= dif_d;
      meta_d_q <= meta_c_q;
      for (int c = 0; c < NUM_AXES; c++) begin
        pd0_q[c] <= pc_q[0][c];
      end
    end
    if (em_load) begin
      k_q      <= k_d;
      meta_e_q <= meta_d_q;
    end
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  // Stage valids, emitter sequencing and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      busy_q      <= 1'b0;
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_a) va_q <= job_valid_i;
      if (adv_b) vb_q <= va_q;
      if (adv_c) vc_q <= vb_q;
      if (adv_d) vd_q <= vc_q;
      if (em_load) begin
        busy_q <= 1'b1;
        beat_q <= '0;
      end else if (out_load) begin
        beat_q <= beat_q + 1'b1;
        if (beat_q == SLOT_K3) begin
          busy_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

>>> src/bezier_curve_record_setup_unit.sv
// ----------------------------------------------------------------------------
// Bezier curve record setup unit
// Usage: items arrive on the in channel (valid/ready, one transfer per cycle).
// Control point and colour items update internal state and give no result.
// Each finish item yields four results on the out channel (valid/ready), the
// coefficients K0 to K3 in order, with last_of_record set on K3.
// After its finish transfer, K0 of a curve passes the job queue, the back-end
// stages, the emitter and the output register; the three further coefficients
// follow one per cycle while out_ready_i is high. Throughput: one input
// transfer per cycle for point and colour items while the queue has room; each
// record holds the single output register for four transfers before the next.
// The front end and back end are parted by a job queue of QUEUE_DEPTH entries
// and a four-stage back-end pipeline, so input keeps flowing while results
// wait. When the receiver stalls, the pipeline and then the queue fill, and
// in_ready_o falls once the queue is full.
// Reset clears the colours to zero, the sample counter and chain start to
// zero and empties the queue and pipeline; control points hold no value
// until written.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_curve_record_setup_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  brcs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output brcs_pkg::out_item_t out_item_o
);
  import brcs_pkg::*;

  localparam int unsigned JobW = $bits(job_t);

  logic            push_valid, push_ready, pop_valid, pop_ready;
  job_t            push_job, pop_job;
  logic [JobW-1:0] pop_data;

  // Front end: item classification and record bookkeeping.
  brcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  // Job queue between the two halves.
  brcs_queue #(
    .WIDTH (JobW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_job = job_t'(pop_data);

  // Back end: coefficient pipeline and result sequencer.
  brcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

>>> src/brcs_checker.sv
// ----------------------------------------------------------------------------
// Bezier curve record setup: port checker
// Concurrent assertions on the result channel of the top level, attached to
// it by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module brcs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input brcs_pkg::out_item_t out_item_o
);
  import brcs_pkg::*;

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Only the K3 result closes a record.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.last_of_record == (out_item_o.coeff_slot == SLOT_K3)))
    else $error("last_of_record does not match the coefficient slot");

  // Within a record the results follow back to back, in slot order, with the
  // same sample range and chain start.
  a_record_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.last_of_record |=>
      out_valid_o && (out_item_o.coeff_slot == $past(out_item_o.coeff_slot) + 2'd1) &&
      (out_item_o.first_sample == $past(out_item_o.first_sample)) &&
      (out_item_o.last_sample == $past(out_item_o.last_sample)) &&
      (out_item_o.chain_first == $past(out_item_o.chain_first)))
    else $error("record results out of order or inconsistent");

  // A curve never ends before its first sample.
  a_sample_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.first_sample <= out_item_o.last_sample))
    else $error("sample range reversed");

endmodule

bind bezier_curve_record_setup_unit brcs_checker u_brcs_checker (.*);

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Bezier curve record setup unit: testbench
// Sends curve description items through the in channel and checks every
// coefficient result against an independent prediction of the curve setup:
// degree raising, power basis conversion, colour packing and sample ranges.
// A directed table opens the run, random phases with varied idling follow,
// and a short run of long curves closes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import brcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned ITEMS_PER_PHASE = 70;
  localparam int unsigned TAIL_ITEMS      = 6;
  localparam int unsigned MAX_REPORTS     = 200;
  localparam longint      ONE_Q           = longint'(1) << FRAC_BITS;

  // One row of stimulus; typed rows carry a flat curve whose results are known.
  typedef struct {
    in_item_t item;
    bit       typed;
    coord_t   k0;
    sample_t  first;
    sample_t  last;
    sample_t  chain;
    colour_t  c_start;
    colour_t  c_end;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Shadow state of the curve setup.
  coord_t  curve_pts [4][3];
  colour_t start_word  = '0;
  colour_t end_word    = '0;
  sample_t sample_next = '0;
  sample_t chain_head  = '0;
  bit      curve_seen  = 1'b0;

  out_item_t curve_coeffs [4];
  out_item_t awaited_coeffs [$];
  stim_row_t directed_rows [$];

  bezier_curve_record_setup_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Nearest integer to n/3, i.e. floor((n + 1) / 3).
  function automatic longint third_round(input longint n);
    longint m;
    longint quo;
    m   = n + 1;
    quo = m / 3;
    if (m % 3 < 0) quo = quo - 1;
    return quo;
  endfunction

  function automatic coeff_t clamp_coeff(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COEFF_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return coeff_t'(v);
  endfunction

  // Clamp a Q16.16 channel to [0, 1.0] and scale it to a rounded byte.
  function automatic logic [7:0] colour_byte(input coord_t v);
    longint s;
    s = v;
    if (s < 0) s = 0;
    if (s > ONE_Q) s = ONE_Q;
    return 8'((s * 255 + (ONE_Q >>> 1)) >>> FRAC_BITS);
  endfunction

  function automatic colour_t pack_colour(input in_item_t it);
    return {8'hFF, colour_byte(it.value_z), colour_byte(it.value_y),
            colour_byte(it.value_x)};
  endfunction

  // Updates the shadow state for one transfer and fills curve_coeffs on a
  // finish item; returns the number of results the item causes.
  function automatic int setup_curve(input in_item_t it);
    longint a, b, d, e;
    longint p0, p1, p2, p3;
    longint d10, d21, d32, dd0, dd1;
    longint q [4][3];
    longint first, last, count;
    bit     new_chain;
    int     ax;
    int     k;
    case (it.kind)
      KIND_POINT: begin
        curve_pts[it.point_slot][0] = it.value_x;
        curve_pts[it.point_slot][1] = it.value_y;
        curve_pts[it.point_slot][2] = it.value_z;
        return 0;
      end
      KIND_START_COLOUR: begin
        start_word = pack_colour(it);
        return 0;
      end
      KIND_END_COLOUR: begin
        end_word = pack_colour(it);
        return 0;
      end
      default: ;
    endcase

    for (ax = 0; ax < 3; ax++) begin
      a  = curve_pts[0][ax];
      b  = curve_pts[1][ax];
      d  = curve_pts[2][ax];
      e  = curve_pts[3][ax];
      p0 = a;
      // Linear and quadratic curves are raised to cubic; other codes are cubic.
      if (it.degree == DEG_LINEAR) begin
        p1 = third_round(2 * a + b);
        p2 = third_round(a + 2 * b);
        p3 = b;
      end else if (it.degree == DEG_QUAD) begin
        p1 = third_round(a + 2 * b);
        p2 = third_round(2 * b + d);
        p3 = d;
      end else begin
        p1 = b;
        p2 = d;
        p3 = e;
      end
      d10 = p1 - p0;
      d21 = p2 - p1;
      d32 = p3 - p2;
      dd0 = d21 - d10;
      dd1 = d32 - d21;
      q[0][ax] = p0;
      q[1][ax] = 3 * d10;
      q[2][ax] = 3 * dd0;
      q[3][ax] = dd1 - dd0;
    end

    // A joined curve shares the previous curve's last sample.
    new_chain = !curve_seen || !it.joins_previous;
    if (new_chain) first = longint'(sample_next);
    else first = (sample_next > 0) ? longint'(sample_next) - 1 : 0;
    count = (it.sample_count == 16'd0) ? 1 : longint'(it.sample_count);
    last  = first + count - 1;
    if (last > longint'(SAMPLE_MAX)) last = longint'(SAMPLE_MAX);
    sample_next = (last + 1 > longint'(SAMPLE_MAX)) ? SAMPLE_MAX : sample_t'(last + 1);
    if (new_chain) chain_head = sample_t'(first);
    curve_seen = 1'b1;

    for (k = 0; k < 4; k++) begin
      curve_coeffs[k].coeff_x        = clamp_coeff(q[k][0]);
      curve_coeffs[k].coeff_y        = clamp_coeff(q[k][1]);
      curve_coeffs[k].coeff_z        = clamp_coeff(q[k][2]);
      curve_coeffs[k].coeff_slot     = 2'(k);
      curve_coeffs[k].first_sample   = sample_t'(first);
      curve_coeffs[k].last_sample    = sample_t'(last);
      curve_coeffs[k].chain_first    = chain_head;
      curve_coeffs[k].colour_start   = start_word;
      curve_coeffs[k].colour_end     = end_word;
      curve_coeffs[k].last_of_record = (2'(k) == SLOT_K3);
    end
    return 4;
  endfunction

  // Result k of a typed row: a flat curve gives K0 = P and zero elsewhere.
  function automatic out_item_t flat_record(input stim_row_t row, input int k);
    out_item_t rec;
    rec.coeff_x        = (k == 0) ? coeff_t'(row.k0) : '0;
    rec.coeff_y        = (k == 0) ? coeff_t'(row.k0) : '0;
    rec.coeff_z        = (k == 0) ? coeff_t'(row.k0) : '0;
    rec.coeff_slot     = 2'(k);
    rec.first_sample   = row.first;
    rec.last_sample    = row.last;
    rec.chain_first    = row.chain;
    rec.colour_start   = row.c_start;
    rec.colour_end     = row.c_end;
    rec.last_of_record = (2'(k) == SLOT_K3);
    return rec;
  endfunction

  function automatic stim_row_t plain_row(input kind_e kind, input coord_t x, input coord_t y,
                                          input coord_t z, input logic [1:0] slot,
                                          input logic [1:0] deg, input logic [15:0] cnt,
                                          input logic joins);
    stim_row_t row;
    row.item.kind           = kind;
    row.item.value_x        = x;
    row.item.value_y        = y;
    row.item.value_z        = z;
    row.item.point_slot     = slot;
    row.item.degree         = deg;
    row.item.sample_count   = cnt;
    row.item.joins_previous = joins;
    row.typed               = 1'b0;
    return row;
  endfunction

  function automatic stim_row_t flat_finish(input logic [1:0] deg, input logic [15:0] cnt,
                                            input logic joins, input coord_t k0,
                                            input sample_t first, input sample_t last,
                                            input sample_t chain, input colour_t c_start,
                                            input colour_t c_end);
    stim_row_t row;
    row         = plain_row(KIND_FINISH, '0, '0, '0, 2'd0, deg, cnt, joins);
    row.typed   = 1'b1;
    row.k0      = k0;
    row.first   = first;
    row.last    = last;
    row.chain   = chain;
    row.c_start = c_start;
    row.c_end   = c_end;
    return row;
  endfunction

  // Coordinates mixing full-range, small, colour-range and boundary values.
  function automatic coord_t random_value();
    coord_t corners [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000};
    case ($urandom_range(4))
      0:       return $urandom();
      1:       return coord_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2:       return coord_t'($urandom_range(0, 32'h0001_8000)) - 32'sh0000_4000;
      3:       return corners[$urandom_range(3)];
      default: return coord_t'($signed($urandom()) >>> $urandom_range(31));
    endcase
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t   row;
    int unsigned pick;
    row  = plain_row(KIND_POINT, random_value(), random_value(), random_value(),
                     2'($urandom_range(3)), 2'($urandom_range(3)), 16'd0,
                     1'($urandom_range(1)));
    pick = $urandom_range(99);
    if (pick < 40) row.item.kind = KIND_POINT;
    else if (pick < 50) row.item.kind = KIND_START_COLOUR;
    else if (pick < 60) row.item.kind = KIND_END_COLOUR;
    else row.item.kind = KIND_FINISH;
    pick = $urandom_range(19);
    if (pick == 0) row.item.sample_count = 16'($urandom_range(1));
    else if (pick == 1) row.item.sample_count = 16'hFFFF;
    else if (pick < 5) row.item.sample_count = 16'($urandom());
    else row.item.sample_count = 16'($urandom_range(2, 64));
    return row;
  endfunction

  // Offers one item, with random idle cycles first, until the transfer.
  task automatic issue(input stim_row_t row);
    int n;
    int k;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= row.item;
    do @(posedge clk_i); while (!in_ready_o);
    n = setup_curve(row.item);
    for (k = 0; k < n; k++)
      awaited_coeffs.insert(awaited_coeffs.size(),
                            row.typed ? flat_record(row, k) : curve_coeffs[k]);
  endtask

  task automatic report_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: expected %h, got %h", $time, what, want, got);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (awaited_coeffs.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t result with nothing expected: expected none, got %h", $time, got);
      return;
    end
    want = awaited_coeffs.pop_front();
    if (got.coeff_x !== want.coeff_x) report_field("coeff_x", want.coeff_x, got.coeff_x);
    if (got.coeff_y !== want.coeff_y) report_field("coeff_y", want.coeff_y, got.coeff_y);
    if (got.coeff_z !== want.coeff_z) report_field("coeff_z", want.coeff_z, got.coeff_z);
    if (got.coeff_slot !== want.coeff_slot)
      report_field("coeff_slot", want.coeff_slot, got.coeff_slot);
    if (got.first_sample !== want.first_sample)
      report_field("first_sample", want.first_sample, got.first_sample);
    if (got.last_sample !== want.last_sample)
      report_field("last_sample", want.last_sample, got.last_sample);
    if (got.chain_first !== want.chain_first)
      report_field("chain_first", want.chain_first, got.chain_first);
    if (got.colour_start !== want.colour_start)
      report_field("colour_start", want.colour_start, got.colour_start);
    if (got.colour_end !== want.colour_end)
      report_field("colour_end", want.colour_end, got.colour_end);
    if (got.last_of_record !== want.last_of_record)
      report_field("last_of_record", want.last_of_record, got.last_of_record);
  endtask

  // Result side: check each transfer and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(out_item_o);
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bezier_curve_record_setup_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned idle_plan  [4];
    int unsigned stall_plan [4];
    int          slot;
    int          ph;
    int          n;
    stim_row_t   row;

    idle_plan  = '{0, 57, 0, 31};
    stall_plan = '{0, 0, 57, 31};

    // Directed table. Every control point is written before the first finish.
    for (slot = 0; slot < 4; slot++)
      directed_rows.insert(directed_rows.size(),
                           plain_row(KIND_POINT, '0, '0, '0, 2'(slot), 2'd0, 16'd0, 1'b0));
    // First curve after reset starts a chain even when marked as joined.
    directed_rows.insert(directed_rows.size(),
                         flat_finish(2'd3, 16'd2, 1'b1, '0, 0, 1, 0, '0, '0));
    // Channels above one, negative and exactly one or one half.
    directed_rows.insert(directed_rows.size(),
                         plain_row(KIND_START_COLOUR, 32'h0001_0000, 32'hFFFF_FFFF,
                                   32'h7FFF_FFFF, 2'd0, 2'd0, 16'd0, 1'b0));
    directed_rows.insert(directed_rows.size(),
                         plain_row(KIND_END_COLOUR, 32'h8000_0000, 32'h0000_8000,
                                   32'h0000_0000, 2'd0, 2'd0, 16'd0, 1'b0));
    for (slot = 0; slot < 4; slot++)
      directed_rows.insert(directed_rows.size(),
                           plain_row(KIND_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     32'h7FFF_FFFF, 2'(slot), 2'd0, 16'd0, 1'b0));
    // Degree code zero, count zero, joined onto the previous last sample.
    directed_rows.insert(directed_rows.size(),
                         flat_finish(2'd0, 16'd0, 1'b1, 32'h7FFF_FFFF, 1, 1, 0,
                                     32'hFFFF_00FF, 32'hFF00_8000));
    for (slot = 0; slot < 4; slot++)
      directed_rows.insert(directed_rows.size(),
                           plain_row(KIND_POINT, 32'h8000_0000, 32'h8000_0000,
                                     32'h8000_0000, 2'(slot), 2'd0, 16'd0, 1'b0));
    // Linear, count one, new chain.
    directed_rows.insert(directed_rows.size(),
                         flat_finish(DEG_LINEAR, 16'd1, 1'b0, 32'h8000_0000, 2, 2, 2,
                                     32'hFFFF_00FF, 32'hFF00_8000));
    directed_rows.insert(directed_rows.size(),
                         plain_row(KIND_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h7FFF_FFFF, 2'd3, 2'd0, 16'd0, 1'b0));
    directed_rows.insert(directed_rows.size(),
                         plain_row(KIND_FINISH, '0, '0, '0, 2'd0, 2'd3, 16'hFFFF, 1'b1));
    directed_rows.insert(directed_rows.size(),
                         plain_row(KIND_POINT, 32'h1234_5678, 32'hEDCB_A987,
                                   32'h0001_8000, 2'd1, 2'd0, 16'd0, 1'b0));
    directed_rows.insert(directed_rows.size(),
                         plain_row(KIND_FINISH, '0, '0, '0, 2'd0, DEG_QUAD, 16'd7, 1'b0));
    directed_rows.insert(directed_rows.size(),
                         plain_row(KIND_FINISH, '0, '0, '0, 2'd0, DEG_LINEAR, 16'd3, 1'b1));
    directed_rows.insert(directed_rows.size(),
                         plain_row(KIND_START_COLOUR, 32'h0000_4000, 32'h0000_FFFF,
                                   32'h0001_0001, 2'd0, 2'd0, 16'd0, 1'b0));
    directed_rows.insert(directed_rows.size(),
                         plain_row(KIND_FINISH, '0, '0, '0, 2'd0, 2'd3, 16'hFFFF, 1'b0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) issue(directed_rows[i]);

    // Random phases with different idling on each side.
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      stall_pct     = stall_plan[ph];
      for (n = 0; n < ITEMS_PER_PHASE; n++) issue(random_row());
    end

    // A short run of long curves, back to back.
    send_idle_pct = 0;
    stall_pct     = 0;
    for (n = 0; n < TAIL_ITEMS; n++) begin
      row                   = random_row();
      row.item.kind         = KIND_FINISH;
      row.item.sample_count = 16'hFFFF;
      issue(row);
    end
    in_valid_i <= 1'b0;

    while (awaited_coeffs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && awaited_coeffs.size() == 0)
      $display("bezier_curve_record_setup_unit: match");
    else
      $display("bezier_curve_record_setup_unit: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/brcs_pkg.sv
src/brcs_front.sv
src/brcs_queue.sv
src/brcs_back.sv
src/bezier_curve_record_setup_unit.sv
src/brcs_checker.sv
bench/tb_top.sv
